// File: rtl/decimal_integer_formatter_assert.svh
// assertion macros for the decimal integer formatter checker
// expects signals named clk and rst in the scope of use
`ifndef DECIMAL_INTEGER_FORMATTER_ASSERT_SVH
`define DECIMAL_INTEGER_FORMATTER_ASSERT_SVH

// checked only outside reset
`define DIF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every edge, reset included
`define DIF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/dif_pkg.sv
// shared widths, register indexes and character codes of the decimal formatter
// no dependencies
`default_nettype none

package dif_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 7;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int MAX_FIELD   = 48;
  localparam int DIGIT_SLOTS = 10;
  localparam int BCD_W       = DIGIT_SLOTS * 4;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRECISION    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_PLUS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_SIGN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PAD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_JUSTIFY = 3'd5;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;

endpackage

`default_nettype wire

// File: rtl/dif_if.sv
// valid/ready channel interfaces: input value, output character, config write
// depends on dif_pkg
`default_nettype none

interface dif_in_if import dif_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface dif_out_if import dif_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;
  logic [LEN_W-1:0]  total_length;
  modport source (output valid, output out_char, output last_char, output total_length,
                  input ready);
  modport sink (input valid, input out_char, input last_char, input total_length,
                output ready);
endinterface

interface dif_cfg_if import dif_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/decimal_integer_formatter.sv
// decimal_integer_formatter: printf %d style text of a signed 32-bit value
// depends on dif_pkg and the channel interfaces in dif_if.sv
//
// usage
//   item   : one signed 32-bit value per request, taken only while idle
//   result : one ascii character per request, last_char on the final one,
//            total_length carries the character count of the whole text
//   cfg    : register writes, always ready; write only while the block is idle
// timing
//   a value spends 32 cycles in the shift-add-3 binary to bcd unit, then
//   2 cycles of length planning, then one character per cycle as long as
//   result is not stalled, plus one cycle per empty text segment (up to 4)
//   one value takes 35 + total_length cycles plus those empty segments; the
//   bcd shift loop and the one-character output register set that figure
//   a value with an empty text gives no result and the block is ready again
// reset and stall
//   rst clears the sequencer and the output valid, and restores the register
//   defaults (no precision, no flags, zero width)
//   a stalled result holds its character; the sequencer waits on it
`default_nettype none

module decimal_integer_formatter import dif_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  dif_in_if.sink       item,
  dif_out_if.source    result,
  dif_cfg_if.sink      cfg
);

  typedef enum logic [2:0] {ST_IDLE, ST_CONV, ST_CALC, ST_PLAN, ST_EMIT} state_t;

  localparam logic [2:0] SEG_LEAD  = 3'd0;
  localparam logic [2:0] SEG_SIGN  = 3'd1;
  localparam logic [2:0] SEG_ZERO  = 3'd2;
  localparam logic [2:0] SEG_DIGIT = 3'd3;
  localparam logic [2:0] SEG_TRAIL = 3'd4;
  localparam int         SEG_N     = 5;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FIELD);

  // config registers
  logic [LEN_W-1:0]      min_width;
  logic [CFG_DATA_W-1:0] precision;
  logic                  force_plus;
  logic                  space_sign;
  logic                  zero_pad;
  logic                  left_justify;

  state_t               state;
  logic [VALUE_W-1:0]   mag;
  logic [BCD_W-1:0]     bcd;
  logic [4:0]           bit_cnt;
  logic                 neg;
  logic [3:0]           ndig;
  logic [LEN_W-1:0]     digit_field;
  logic [LEN_W-1:0]     width_s;
  logic                 has_sign;
  logic [CHAR_W-1:0]    sign_ch;
  logic [LEN_W-1:0]     total;
  logic [LEN_W-1:0]     remain;
  logic [2:0]           seg;
  logic [LEN_W-1:0]     cnt;
  logic [LEN_W-1:0]     seg_len [SEG_N];

  logic                 out_valid;
  logic [CHAR_W-1:0]    out_char;
  logic                 last_char;
  logic [LEN_W-1:0]     total_length;

  logic [BCD_W-1:0]     bcd_adj;
  logic [3:0]           ndig_raw;
  logic [3:0]           ndig_c;
  logic                 has_prec;
  logic [LEN_W-1:0]     prec_s;
  logic [LEN_W-1:0]     digit_field_c;
  logic [LEN_W-1:0]     body_len;
  logic [LEN_W-1:0]     total_c;
  logic [LEN_W-1:0]     pad;
  logic                 zeros;
  logic [LEN_W-1:0]     plan_len [SEG_N];
  logic [2:0]           seg_inc;
  logic [LEN_W-1:0]     next_len;
  logic [3:0]           dig_idx;
  logic [3:0]           dig_val;
  logic [CHAR_W-1:0]    cur_char;
  logic                 emit_ok;
  logic                 emit_fire;

  assign item.ready          = (state == ST_IDLE);
  assign cfg.ready           = 1'b1;
  assign result.valid        = out_valid;
  assign result.out_char     = out_char;
  assign result.last_char    = last_char;
  assign result.total_length = total_length;

  assign emit_ok   = !out_valid || result.ready;
  assign emit_fire = (state == ST_EMIT) && (cnt != '0) && emit_ok;

  // add-3 correction of every bcd digit
  always_comb begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  // digit count and saturated precision
  always_comb begin
    ndig_raw = '0;
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        ndig_raw = 4'(i + 1);
      end
    end
    has_prec = !precision[CFG_DATA_W-1];
    if (!has_prec) begin
      prec_s = '0;
    end else if (precision[LEN_W-1:0] > MAX_LEN) begin
      prec_s = MAX_LEN;
    end else begin
      prec_s = precision[LEN_W-1:0];
    end
    if (ndig_raw != 4'd0) begin
      ndig_c = ndig_raw;
    end else if (has_prec && prec_s == '0) begin
      ndig_c = 4'd0;
    end else begin
      ndig_c = 4'd1;
    end
    digit_field_c = (prec_s > LEN_W'(ndig_c)) ? prec_s : LEN_W'(ndig_c);
  end

  // segment lengths of the text
  always_comb begin
    body_len = digit_field + LEN_W'(has_sign);
    total_c  = (width_s > body_len) ? width_s : body_len;
    pad      = total_c - body_len;
    zeros    = zero_pad && precision[CFG_DATA_W-1] && !left_justify;
    plan_len[SEG_LEAD]  = (!left_justify && !zeros) ? pad : '0;
    plan_len[SEG_SIGN]  = LEN_W'(has_sign);
    plan_len[SEG_ZERO]  = (zeros ? pad : '0) + digit_field - LEN_W'(ndig);
    plan_len[SEG_DIGIT] = LEN_W'(ndig);
    plan_len[SEG_TRAIL] = left_justify ? pad : '0;
  end

  // current character
  always_comb begin
    seg_inc = seg + 3'd1;
    case (seg_inc)
      SEG_SIGN:  next_len = seg_len[SEG_SIGN];
      SEG_ZERO:  next_len = seg_len[SEG_ZERO];
      SEG_DIGIT: next_len = seg_len[SEG_DIGIT];
      SEG_TRAIL: next_len = seg_len[SEG_TRAIL];
      default:   next_len = '0;
    endcase
    dig_idx = 4'(cnt - LEN_W'(1));
    dig_val = '0;
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      if (dig_idx == 4'(i)) begin
        dig_val = bcd[i*4 +: 4];
      end
    end
    case (seg)
      SEG_SIGN:  cur_char = sign_ch;
      SEG_ZERO:  cur_char = CH_ZERO;
      SEG_DIGIT: cur_char = CH_ZERO + CHAR_W'(dig_val);
      default:   cur_char = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      min_width    <= '0;
      precision    <= '1;
      force_plus   <= 1'b0;
      space_sign   <= 1'b0;
      zero_pad     <= 1'b0;
      left_justify <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_MIN_WIDTH:    min_width    <= cfg.data[LEN_W-1:0];
          REG_PRECISION:    precision    <= cfg.data;
          REG_FORCE_PLUS:   force_plus   <= cfg.data[0];
          REG_SPACE_SIGN:   space_sign   <= cfg.data[0];
          REG_ZERO_PAD:     zero_pad     <= cfg.data[0];
          REG_LEFT_JUSTIFY: left_justify <= cfg.data[0];
          default: ;
        endcase
      end

      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            neg     <= item.value[VALUE_W-1];
            mag     <= item.value[VALUE_W-1] ? VALUE_W'(-item.value) : VALUE_W'(item.value);
            bcd     <= '0;
            bit_cnt <= '0;
            state   <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
          mag     <= {mag[VALUE_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == 5'(VALUE_W - 1)) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          ndig        <= ndig_c;
          digit_field <= digit_field_c;
          width_s     <= (min_width > MAX_LEN) ? MAX_LEN : min_width;
          has_sign    <= neg || force_plus || space_sign;
          if (neg) begin
            sign_ch <= CH_MINUS;
          end else if (force_plus) begin
            sign_ch <= CH_PLUS;
          end else begin
            sign_ch <= CH_SPACE;
          end
          state <= ST_PLAN;
        end
        ST_PLAN: begin
          for (int i = 0; i < SEG_N; i++) begin
            seg_len[i] <= plan_len[i];
          end
          total  <= total_c;
          remain <= total_c;
          seg    <= SEG_LEAD;
          cnt    <= plan_len[SEG_LEAD];
          state  <= (total_c == '0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (cnt == '0) begin
            if (seg != SEG_TRAIL) begin
              seg <= seg_inc;
              cnt <= next_len;
            end
          end else if (emit_ok) begin
            out_char     <= cur_char;
            last_char    <= (remain == LEN_W'(1));
            total_length <= total;
            remain       <= remain - LEN_W'(1);
            if (cnt == LEN_W'(1) && seg != SEG_TRAIL) begin
              seg <= seg_inc;
              cnt <= next_len;
            end else begin
              cnt <= cnt - LEN_W'(1);
            end
            if (remain == LEN_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/dif_checker.sv
// port-level checks of the decimal formatter and the bind that attaches them
// depends on dif_pkg and decimal_integer_formatter_assert.svh
`default_nettype none

`include "decimal_integer_formatter_assert.svh"

module dif_checker import dif_pkg::*; (
  input wire             clk,
  input wire             rst,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input wire             last_char,
  input wire [LEN_W-1:0] total_length
);

  `DIF_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !out_valid, "result valid right after reset")
  `DIF_ASSERT(a_busy_after_request, in_valid && in_ready |=> !in_ready, "ready while converting")
  `DIF_ASSERT(a_no_request_mid_text, out_valid && !last_char |-> !in_ready, "ready mid text")
  `DIF_ASSERT(a_hold_while_stalled, out_valid && !out_ready |=> out_valid && total_length == $past(total_length), "stalled result dropped or changed")
  `DIF_ASSERT(a_length_range, out_valid |-> total_length != '0 && 32'(total_length) <= MAX_FIELD + 1, "length out of range")

endmodule

bind decimal_integer_formatter dif_checker u_dif_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item.valid),
  .in_ready     (item.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .last_char    (result.last_char),
  .total_length (result.total_length)
);

`default_nettype wire

// File: bench/text_checker.sv
`timescale 1ns / 1ps
// text_checker: watches the value, character and register-write channels of the formatter,
// predicts the printf %d text of every accepted value and compares it character by character
// depends on dif_pkg and the channel interfaces in rtl/dif_if.sv
module text_checker import dif_pkg::*; (
  input  logic clk,
  input  logic rst,
  dif_in_if    item,
  dif_out_if   result,
  dif_cfg_if   cfg,
  output int   error_count,
  output int   chars_owed
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [LEN_W-1:0]  len;
  } text_char_t;

  logic [5:0] min_width_q;
  logic [6:0] precision_q;
  logic       force_plus_q;
  logic       space_sign_q;
  logic       zero_pad_q;
  logic       left_justify_q;

  text_char_t owed_text[$];
  text_char_t oldest;
  int         mismatches = 0;

  assign error_count = mismatches;

  function automatic void predict_text(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  sign_ch;
    logic [CHAR_W-1:0]  chars[$];
    logic [3:0]         digits[DIGIT_SLOTS];
    bit                 has_prec;
    bit                 has_sign;
    bit                 zeros;
    int                 prec;
    int                 width;
    int                 ndig;
    int                 digit_field;
    int                 body_len;
    int                 total;
    int                 pad;
    int                 i;
    mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    has_prec = !precision_q[6];
    prec = has_prec ? int'(precision_q) : 0;
    if (prec > MAX_FIELD) prec = MAX_FIELD;
    width = int'(min_width_q);
    if (width > MAX_FIELD) width = MAX_FIELD;

    foreach (digits[k]) digits[k] = 4'd0;
    ndig = 0;
    while (mag != 0) begin
      digits[ndig] = 4'(mag % 10);
      mag = mag / 10;
      ndig++;
    end
    if (ndig == 0) ndig = (has_prec && prec == 0) ? 0 : 1;

    has_sign = 1'b1;
    if (raw[VALUE_W-1]) sign_ch = CH_MINUS;
    else if (force_plus_q) sign_ch = CH_PLUS;
    else if (space_sign_q) sign_ch = CH_SPACE;
    else has_sign = 1'b0;

    digit_field = (prec > ndig) ? prec : ndig;
    body_len = digit_field + (has_sign ? 1 : 0);
    total = (width > body_len) ? width : body_len;
    pad = total - body_len;
    zeros = zero_pad_q && !has_prec && !left_justify_q;

    if (!left_justify_q && !zeros) repeat (pad) chars.push_back(CH_SPACE);
    if (has_sign) chars.push_back(sign_ch);
    if (zeros) repeat (pad) chars.push_back(CH_ZERO);
    repeat (digit_field - ndig) chars.push_back(CH_ZERO);
    for (i = ndig - 1; i >= 0; i--) chars.push_back(CHAR_W'(CH_ZERO + digits[i]));
    if (left_justify_q) repeat (pad) chars.push_back(CH_SPACE);

    foreach (chars[k])
      owed_text.push_back('{ch: chars[k], last: (k == chars.size() - 1), len: LEN_W'(total)});
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      min_width_q    = '0;
      precision_q    = '1;
      force_plus_q   = 1'b0;
      space_sign_q   = 1'b0;
      zero_pad_q     = 1'b0;
      left_justify_q = 1'b0;
      owed_text.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MIN_WIDTH:    min_width_q    = cfg.data[5:0];
          REG_PRECISION:    precision_q    = cfg.data[6:0];
          REG_FORCE_PLUS:   force_plus_q   = cfg.data[0];
          REG_SPACE_SIGN:   space_sign_q   = cfg.data[0];
          REG_ZERO_PAD:     zero_pad_q     = cfg.data[0];
          REG_LEFT_JUSTIFY: left_justify_q = cfg.data[0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) predict_text(item.value);
      if (result.valid && result.ready) begin
        if (owed_text.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected character %h last %b len %0d", $realtime,
                     result.out_char, result.last_char, result.total_length);
        end else begin
          oldest = owed_text.pop_front();
          if ({result.out_char, result.last_char, result.total_length} !== oldest) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected char %h last %b len %0d, got char %h last %b len %0d",
                       $realtime, oldest.ch, oldest.last, oldest.len,
                       result.out_char, result.last_char, result.total_length);
          end
        end
      end
    end
    chars_owed <= owed_text.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// testbench: drives values and register writes into decimal_integer_formatter under
// several formatting settings and idling patterns; text_checker does the comparison
// depends on dif_pkg, rtl/dif_if.sv, the formatter and bench/text_checker.sv
module testbench;
  import dif_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 120;
  localparam int HOLD_CYCLES     = 600;
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 28;
  localparam int PRESSURE_PHASE  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    int width;
    int prec;
    bit force_plus;
    bit space_sign;
    bit zero_pad;
    bit left_justify;
  } fmt_setting_t;

  logic clk = 1'b0;
  logic rst;

  int   idle_pct = 0;
  int   stall_pct = 0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   phase;
  int   error_count;
  int   chars_owed;

  int directed_values[10] = '{0, 1, -1, 7, 10, -10, 32'sh7FFF_FFFF, 32'sh8000_0000,
                              1000000000, -999999999};
  int corner_values[8] = '{0, 1, -1, 9, 99, -100, 32'sh7FFF_FFFF, 32'sh8000_0000};

  fmt_setting_t fixed_settings[9] = '{
    '{0, -1, 0, 0, 0, 0},
    '{63, 63, 1, 1, 0, 0},
    '{0, 0, 0, 0, 0, 0},
    '{12, -1, 1, 0, 1, 0},
    '{12, -1, 0, 1, 1, 1},
    '{20, 5, 0, 0, 1, 0},
    '{48, -64, 0, 1, 1, 0},
    '{5, 0, 0, 1, 0, 1},
    '{0, 48, 1, 0, 0, 1}
  };

  always #5 clk = ~clk;

  dif_in_if  item();
  dif_out_if result();
  dif_cfg_if cfg();

  decimal_integer_formatter dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  text_checker text_check (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .cfg         (cfg),
    .error_count (error_count),
    .chars_owed  (chars_owed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver side, with a long hold-off on request
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid <= 1'b1;
    item.value <= v;
    do @(posedge clk); while (!item.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic apply_setting(input fmt_setting_t s);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_MIN_WIDTH, {1'($urandom), 6'(s.width)});
    write_reg(REG_PRECISION, CFG_DATA_W'(s.prec));
    write_reg(REG_FORCE_PLUS, {6'($urandom), s.force_plus});
    write_reg(REG_SPACE_SIGN, {6'($urandom), s.space_sign});
    write_reg(REG_ZERO_PAD, {6'($urandom), s.zero_pad});
    write_reg(REG_LEFT_JUSTIFY, {6'($urandom), s.left_justify});
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg.valid <= 1'b0;
  endtask

  // wait for the text to drain, then for the DRAIN_CYCLES drain period
  task automatic finish_phase();
    item.valid <= 1'b0;
    do @(posedge clk); while (chars_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic fmt_setting_t random_setting();
    fmt_setting_t s;
    s.width = ($urandom_range(0, 3) == 0) ? $urandom_range(49, 63) : $urandom_range(0, 20);
    case ($urandom_range(0, 3))
      0: s.prec = -1;
      1: s.prec = -int'($urandom_range(2, 64));
      2: s.prec = $urandom_range(0, 20);
      default: s.prec = $urandom_range(21, 63);
    endcase
    s.force_plus   = $urandom_range(0, 1);
    s.space_sign   = $urandom_range(0, 1);
    s.zero_pad     = $urandom_range(0, 1);
    s.left_justify = $urandom_range(0, 1);
    return s;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = corner_values[$urandom_range(0, 7)];
      1, 2: v = $urandom_range(0, 99);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1)) v = ~v + 1'b1;
    return v;
  endfunction

  initial begin
    rst        <= 1'b1;
    item.valid <= 1'b0;
    item.value <= '0;
    cfg.valid  <= 1'b0;
    cfg.index  <= REG_MIN_WIDTH;
    cfg.data   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_values[i]) send_value(directed_values[i]);
    finish_phase();

    for (phase = 0; phase < PHASES; phase++) begin
      case (idle_mode_t'(phase % 4))
        IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
        IDLE_SENDER:   begin idle_pct = 45; stall_pct = 0;  end
        IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 45; end
        default:       begin idle_pct = 35; stall_pct = 35; end
      endcase
      if (phase < $size(fixed_settings)) apply_setting(fixed_settings[phase]);
      else apply_setting(random_setting());
      if (phase == PRESSURE_PHASE) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_value(pick_value());
      finish_phase();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/dif_pkg.sv
rtl/dif_if.sv
rtl/decimal_integer_formatter.sv
rtl/dif_checker.sv
bench/text_checker.sv
bench/testbench.sv
